FILE: sv/ssa_pkg.sv
package ssa_pkg;

    localparam int NUM_PAGES = 16;
    localparam int MAX_SLOTS = 64;
    localparam int PW        = $clog2(NUM_PAGES);
    localparam int LW        = $clog2(NUM_PAGES + 1);
    localparam int SW        = $clog2(MAX_SLOTS);
    localparam int CW        = $clog2(MAX_SLOTS + 1);

    localparam logic [6:0] SLOTS_RESET = 7'd64;
    localparam logic [4:0] KEEP_RESET  = 5'd3;

    localparam logic [1:0] REG_SLOTS  = 2'd0;
    localparam logic [1:0] REG_KEEP   = 2'd1;
    localparam logic [1:0] REG_RANDOM = 2'd2;
    localparam logic [1:0] REG_SEED   = 2'd3;

    localparam logic [1:0] HOME_POOL    = 2'd0;
    localparam logic [1:0] HOME_EMPTY   = 2'd1;
    localparam logic [1:0] HOME_PARTIAL = 2'd2;
    localparam logic [1:0] HOME_FULL    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOMEM     = 3'd1;
    localparam logic [2:0] ST_NOT_OWNED = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_DOUBLE    = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [4:0]    keep;
        logic [SW-1:0] start;
        logic          busy;
    } ssa_cfg_t;

    typedef struct packed {
        logic [NUM_PAGES-1:0][PW-1:0] e;
        logic [LW-1:0]                len;
    } ssa_list_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_page;
        logic [5:0]  granted_slot;
        logic [10:0] used_slots_total;
        logic [4:0]  held_pages;
    } ssa_result_t;

    function automatic ssa_list_t list_push(ssa_list_t l, logic [PW-1:0] page);
        ssa_list_t r;
        r = l;
        if (l.len < LW'(NUM_PAGES))
        begin
            r.e   = {l.e[NUM_PAGES-2:0], page};
            r.len = l.len + 1'b1;
        end
        return r;
    endfunction

    function automatic ssa_list_t list_remove(ssa_list_t l, logic [PW-1:0] page);
        ssa_list_t r;
        logic      seen;
        logic      hit;
        r    = l;
        seen = 1'b0;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            hit = !seen && (l.e[i] == page) && (LW'(i) < l.len);
            if (hit)
                r.len = l.len - 1'b1;
            seen = seen | hit;
            if (seen && i < NUM_PAGES - 1)
                r.e[i] = l.e[i+1];
        end
        return r;
    endfunction

    function automatic logic [SW:0] first_set(logic [MAX_SLOTS-1:0] v);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = SW'(i);
        end
        return {|v, idx};
    endfunction

endpackage

FILE: sv/ssa_if.sv
interface ssa_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] page_index;
    logic [5:0] slot_index;

    modport source (output valid, command, page_index, slot_index, input ready);
    modport sink   (input valid, command, page_index, slot_index, output ready);
endinterface

interface ssa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  granted_page;
    logic [5:0]  granted_slot;
    logic [10:0] used_slots_total;
    logic [4:0]  held_pages;

    modport source (output valid, status, granted_page, granted_slot, used_slots_total,
                    held_pages, input ready);
    modport sink   (input valid, status, granted_page, granted_slot, used_slots_total,
                    held_pages, output ready);
endinterface

FILE: sv/ssa_cfg.sv
module ssa_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ssa_pkg::ssa_cfg_t  cfg
);

    logic [6:0]              slots_reg;
    logic [4:0]              keep_reg;
    logic                    random_reg;
    logic [31:0]             seed_reg;
    logic                    busy_reg;
    logic [4:0]              bit_reg;
    logic [ssa_pkg::CW-1:0]  rem_reg;
    logic [ssa_pkg::SW-1:0]  start_reg;
    logic [ssa_pkg::CW-1:0]  count;
    logic [ssa_pkg::CW-1:0]  rem_next;
    logic [ssa_pkg::CW:0]    rem_shift;
    logic                    wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        if (slots_reg == 7'd0)
            count = ssa_pkg::CW'(1);
        else if (slots_reg > 7'(ssa_pkg::MAX_SLOTS))
            count = ssa_pkg::CW'(ssa_pkg::MAX_SLOTS);
        else
            count = ssa_pkg::CW'(slots_reg);
    end

    always_comb
    begin
        rem_shift = {rem_reg, seed_reg[bit_reg]};
        if (rem_shift >= {1'b0, count})
            rem_shift = rem_shift - {1'b0, count};
        rem_next = rem_shift[ssa_pkg::CW-1:0];
    end

    always_comb
    begin
        case (paddr[3:2])
            ssa_pkg::REG_SLOTS:  prdata = {25'd0, slots_reg};
            ssa_pkg::REG_KEEP:   prdata = {27'd0, keep_reg};
            ssa_pkg::REG_RANDOM: prdata = {31'd0, random_reg};
            ssa_pkg::REG_SEED:   prdata = seed_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg  <= ssa_pkg::SLOTS_RESET;
            keep_reg   <= ssa_pkg::KEEP_RESET;
            random_reg <= 1'b0;
            seed_reg   <= '0;
            busy_reg   <= 1'b0;
            bit_reg    <= '0;
            rem_reg    <= '0;
            start_reg  <= '0;
        end
        else
        begin
            if (busy_reg)
            begin
                rem_reg <= rem_next;
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == 5'd0)
                begin
                    busy_reg  <= 1'b0;
                    start_reg <= rem_next[ssa_pkg::SW-1:0];
                end
            end
            if (wr)
            begin
                case (paddr[3:2])
                    ssa_pkg::REG_SLOTS:  slots_reg  <= pwdata[6:0];
                    ssa_pkg::REG_KEEP:   keep_reg   <= pwdata[4:0];
                    ssa_pkg::REG_RANDOM: random_reg <= pwdata[0];
                    ssa_pkg::REG_SEED:   seed_reg   <= pwdata;
                    default:             ;
                endcase
                if (paddr[3:2] == ssa_pkg::REG_SLOTS || paddr[3:2] == ssa_pkg::REG_SEED)
                begin
                    busy_reg <= 1'b1;
                    bit_reg  <= 5'd31;
                    rem_reg  <= '0;
                end
            end
        end
    end

    assign cfg.count = count;
    assign cfg.keep  = keep_reg;
    assign cfg.start = random_reg ? start_reg : '0;
    assign cfg.busy  = busy_reg;

endmodule

FILE: sv/ssa_core.sv
module ssa_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  command,
    input  logic [3:0]            page_index,
    input  logic [5:0]            slot_index,
    input  ssa_pkg::ssa_cfg_t     cfg,
    output ssa_pkg::ssa_result_t  result
);

    localparam int NP = ssa_pkg::NUM_PAGES;
    localparam int MS = ssa_pkg::MAX_SLOTS;
    localparam int PW = ssa_pkg::PW;
    localparam int SW = ssa_pkg::SW;
    localparam int CW = ssa_pkg::CW;
    localparam logic [ssa_pkg::LW-1:0] LW_NP = ssa_pkg::LW'(NP);

    logic [NP-1:0][MS-1:0] bitmap_reg, bitmap_next;
    logic [NP-1:0][CW-1:0] used_reg, used_next;
    logic [NP-1:0][1:0]    home_reg, home_next;
    ssa_pkg::ssa_list_t    pool_reg, pool_next;
    ssa_pkg::ssa_list_t    empty_reg, empty_next;
    ssa_pkg::ssa_list_t    part_reg, part_next;
    ssa_pkg::ssa_list_t    full_reg, full_next;
    logic [10:0]           total_reg, total_next;

    logic [MS-1:0]  cnt_mask;
    logic [MS-1:0]  free_bits;
    logic [SW:0]    hi_pick;
    logic [SW:0]    lo_pick;
    logic [PW-1:0]  pg;
    logic [PW-1:0]  q;
    logic [1:0]     h;
    logic [CW-1:0]  uc;
    logic           have;

    assign cnt_mask = (MS'(1) << cfg.count) - MS'(1);

    always_comb
    begin
        bitmap_next = bitmap_reg;
        used_next   = used_reg;
        home_next   = home_reg;
        pool_next   = pool_reg;
        empty_next  = empty_reg;
        part_next   = part_reg;
        full_next   = full_reg;
        total_next  = total_reg;
        result      = '0;
        pg          = page_index[PW-1:0];
        q           = empty_reg.e[0];
        h           = home_reg[pg];
        uc          = used_reg[pg];
        have        = (part_reg.len != '0) || (empty_reg.len != '0) || (pool_reg.len != '0);
        free_bits   = '0;
        hi_pick     = '0;
        lo_pick     = '0;
        result.status = ssa_pkg::ST_OK;
        if (command == ssa_pkg::CMD_ALLOC)
        begin
            if (part_reg.len == '0)
            begin
                if (empty_reg.len == '0 && pool_reg.len != '0)
                begin
                    q              = pool_reg.e[0];
                    pool_next      = ssa_pkg::list_remove(pool_next, q);
                    bitmap_next[q] = '0;
                    used_next[q]   = '0;
                    empty_next     = ssa_pkg::list_push(empty_next, q);
                    home_next[q]   = ssa_pkg::HOME_EMPTY;
                end
                if (have)
                begin
                    q            = empty_next.e[0];
                    empty_next   = ssa_pkg::list_remove(empty_next, q);
                    part_next    = ssa_pkg::list_push(part_next, q);
                    home_next[q] = ssa_pkg::HOME_PARTIAL;
                end
            end
            if (have)
            begin
                pg        = part_next.e[0];
                free_bits = ~bitmap_next[pg] & cnt_mask;
                hi_pick   = ssa_pkg::first_set(free_bits & ({MS{1'b1}} << cfg.start));
                lo_pick   = ssa_pkg::first_set(free_bits);
                if (!hi_pick[SW])
                    hi_pick = lo_pick;
                if (hi_pick[SW])
                begin
                    bitmap_next[pg][hi_pick[SW-1:0]] = 1'b1;
                    uc            = used_next[pg] + 1'b1;
                    used_next[pg] = uc;
                    total_next    = total_reg + 1'b1;
                    if (uc >= cfg.count)
                    begin
                        part_next     = ssa_pkg::list_remove(part_next, pg);
                        full_next     = ssa_pkg::list_push(full_next, pg);
                        home_next[pg] = ssa_pkg::HOME_FULL;
                    end
                    result.granted_page = 4'(pg);
                    result.granted_slot = 6'(hi_pick[SW-1:0]);
                end
                else
                    result.status = ssa_pkg::ST_NOMEM;
            end
            else
                result.status = ssa_pkg::ST_NOMEM;
        end
        else if (h == ssa_pkg::HOME_POOL)
            result.status = ssa_pkg::ST_NOT_OWNED;
        else if (CW'(slot_index) >= cfg.count)
            result.status = ssa_pkg::ST_RANGE;
        else if (!bitmap_reg[pg][slot_index[SW-1:0]])
            result.status = ssa_pkg::ST_DOUBLE;
        else
        begin
            bitmap_next[pg][slot_index[SW-1:0]] = 1'b0;
            if (uc != '0)
                uc = uc - 1'b1;
            used_next[pg] = uc;
            if (total_reg != '0)
                total_next = total_reg - 1'b1;
            if (h == ssa_pkg::HOME_FULL && uc < cfg.count)
            begin
                full_next = ssa_pkg::list_remove(full_next, pg);
                part_next = ssa_pkg::list_push(part_next, pg);
                h         = ssa_pkg::HOME_PARTIAL;
            end
            if (uc == '0 && h == ssa_pkg::HOME_PARTIAL)
            begin
                if (empty_reg.len != '0 && empty_reg.len >= cfg.keep)
                begin
                    empty_next   = ssa_pkg::list_remove(empty_next, q);
                    pool_next    = ssa_pkg::list_push(pool_next, q);
                    home_next[q] = ssa_pkg::HOME_POOL;
                end
                part_next  = ssa_pkg::list_remove(part_next, pg);
                empty_next = ssa_pkg::list_push(empty_next, pg);
                h          = ssa_pkg::HOME_EMPTY;
            end
            home_next[pg] = h;
        end
        result.used_slots_total = total_next;
        result.held_pages       = 5'(LW_NP - pool_next.len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg <= '0;
            used_reg   <= '0;
            home_reg   <= '0;
            for (int i = 0; i < NP; i++)
                pool_reg.e[i] <= PW'(i);
            pool_reg.len <= LW_NP;
            empty_reg    <= '0;
            part_reg     <= '0;
            full_reg     <= '0;
            total_reg    <= '0;
        end
        else if (fire)
        begin
            bitmap_reg <= bitmap_next;
            used_reg   <= used_next;
            home_reg   <= home_next;
            pool_reg   <= pool_next;
            empty_reg  <= empty_next;
            part_reg   <= part_next;
            full_reg   <= full_next;
            total_reg  <= total_next;
        end
    end

endmodule

FILE: sv/slab_slot_allocator_unit.sv
// An accepted beat goes into the input register and its result into the result register.
// Throughput: one beat per cycle unless the response stalls or the config is busy; the
// list update and slot search are combinational. A write to slots_per_page or search_seed
//   holds off input while the serial remainder unit derives the search start slot.
// Reset (rst_n low, asynchronous): every page in the pool, all slots free, registers at defaults.
module slab_slot_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    ssa_req_if.sink     req,
    ssa_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ssa_pkg::ssa_cfg_t    cfg;
    ssa_pkg::ssa_result_t result;
    ssa_pkg::ssa_result_t out_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 cmd_reg;
    logic [3:0]           page_reg;
    logic [5:0]           slot_reg;
    logic                 advance;
    logic                 fire;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = (!in_valid_reg || advance) && !cfg.busy;

    ssa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssa_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .command    (cmd_reg),
        .page_index (page_reg),
        .slot_index (slot_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= req.command;
            page_reg <= req.page_index;
            slot_reg <= req.slot_index;
        end
        if (fire)
            out_reg <= result;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.granted_page     = out_reg.granted_page;
    assign rsp.granted_slot     = out_reg.granted_slot;
    assign rsp.used_slots_total = out_reg.used_slots_total;
    assign rsp.held_pages       = out_reg.held_pages;

endmodule

FILE: sv/ssa_checker.sv
module ssa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [3:0]  granted_page,
    input logic [5:0]  granted_slot,
    input logic [10:0] used_slots_total,
    input logic [4:0]  held_pages
);

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(used_slots_total))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ssa_pkg::ST_OK |-> granted_page == 4'd0 && granted_slot == 6'd0)
        else $error("failed request granted a slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> held_pages <= 5'(ssa_pkg::NUM_PAGES)
            && used_slots_total <= 11'(held_pages) * 11'(ssa_pkg::MAX_SLOTS))
        else $error("slot total exceeds held pages");

endmodule

bind slab_slot_allocator_unit ssa_checker u_ssa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .status           (rsp.status),
    .granted_page     (rsp.granted_page),
    .granted_slot     (rsp.granted_slot),
    .used_slots_total (rsp.used_slots_total),
    .held_pages       (rsp.held_pages)
);

FILE: tb/slab_slot_allocator_unit_checker.sv
module slab_slot_allocator_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    ssa_req_if.sink     req_mon,
    ssa_rsp_if.sink     rsp_mon,
    input  logic [6:0]  slots_cfg,
    input  logic [4:0]  keep_cfg,
    input  logic        random_cfg,
    input  logic [31:0] seed_cfg,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          ok_allocs,
    output int          ok_frees,
    output int          error_results
);
    logic [63:0]          bitmap [ssa_pkg::NUM_PAGES];
    int                   page_used [ssa_pkg::NUM_PAGES];
    logic [1:0]           home [ssa_pkg::NUM_PAGES];
    int                   lists [4][$];
    int                   used_sum;
    ssa_pkg::ssa_result_t awaited_results [$];

    function automatic int slot_limit();
        if (slots_cfg < 1) return 1;
        if (slots_cfg > ssa_pkg::MAX_SLOTS) return ssa_pkg::MAX_SLOTS;
        return int'(slots_cfg);
    endfunction

    function automatic void relocate(int page, logic [1:0] src, logic [1:0] dst);
        for (int i = 0; i < lists[src].size(); i++)
        begin
            if (lists[src][i] == page)
            begin
                lists[src].delete(i);
                break;
            end
        end
        lists[dst].push_front(page);
        home[page] = dst;
    endfunction

    function automatic int scan_free(int page, int from, int cnt);
        for (int i = from; i < cnt; i++)
            if (!bitmap[page][i]) return i;
        return cnt;
    endfunction

    function automatic ssa_pkg::ssa_result_t predict_outcome(logic cmd, int pg, int sl);
        ssa_pkg::ssa_result_t r;
        int cnt, p, start, idx;
        logic ok;
        cnt = slot_limit();
        r = '0;
        r.status = ssa_pkg::ST_OK;
        if (cmd == ssa_pkg::CMD_ALLOC)
        begin
            ok = 1'b1;
            if (lists[ssa_pkg::HOME_PARTIAL].size() == 0)
            begin
                if (lists[ssa_pkg::HOME_EMPTY].size() == 0)
                begin
                    if (lists[ssa_pkg::HOME_POOL].size() == 0)
                        ok = 1'b0;
                    else
                    begin
                        p = lists[ssa_pkg::HOME_POOL][0];
                        bitmap[p] = '0;
                        page_used[p] = 0;
                        relocate(p, ssa_pkg::HOME_POOL, ssa_pkg::HOME_EMPTY);
                    end
                end
                if (ok)
                    relocate(lists[ssa_pkg::HOME_EMPTY][0], ssa_pkg::HOME_EMPTY,
                             ssa_pkg::HOME_PARTIAL);
            end
            if (!ok)
                r.status = ssa_pkg::ST_NOMEM;
            else
            begin
                p = lists[ssa_pkg::HOME_PARTIAL][0];
                start = random_cfg ? int'(seed_cfg % cnt) : 0;
                idx = scan_free(p, start, cnt);
                if (idx >= cnt && start > 0) idx = scan_free(p, 0, cnt);
                if (idx >= cnt)
                    r.status = ssa_pkg::ST_NOMEM;
                else
                begin
                    bitmap[p][idx] = 1'b1;
                    page_used[p]++;
                    used_sum++;
                    if (page_used[p] >= cnt)
                        relocate(p, ssa_pkg::HOME_PARTIAL, ssa_pkg::HOME_FULL);
                    r.granted_page = 4'(p);
                    r.granted_slot = 6'(idx);
                end
            end
        end
        else if (home[pg] == ssa_pkg::HOME_POOL)
            r.status = ssa_pkg::ST_NOT_OWNED;
        else if (sl >= cnt)
            r.status = ssa_pkg::ST_RANGE;
        else if (!bitmap[pg][sl])
            r.status = ssa_pkg::ST_DOUBLE;
        else
        begin
            bitmap[pg][sl] = 1'b0;
            if (page_used[pg] > 0) page_used[pg]--;
            if (used_sum > 0) used_sum--;
            if (home[pg] == ssa_pkg::HOME_FULL && page_used[pg] < cnt)
                relocate(pg, ssa_pkg::HOME_FULL, ssa_pkg::HOME_PARTIAL);
            if (page_used[pg] == 0 && home[pg] == ssa_pkg::HOME_PARTIAL)
            begin
                if (lists[ssa_pkg::HOME_EMPTY].size() > 0 &&
                    lists[ssa_pkg::HOME_EMPTY].size() >= keep_cfg)
                    relocate(lists[ssa_pkg::HOME_EMPTY][0], ssa_pkg::HOME_EMPTY,
                             ssa_pkg::HOME_POOL);
                relocate(pg, ssa_pkg::HOME_PARTIAL, ssa_pkg::HOME_EMPTY);
            end
        end
        r.used_slots_total = 11'(used_sum);
        r.held_pages = 5'(ssa_pkg::NUM_PAGES - lists[ssa_pkg::HOME_POOL].size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssa_pkg::ssa_result_t seen, want, guess;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) lists[i] = {};
            for (int i = 0; i < ssa_pkg::NUM_PAGES; i++)
            begin
                bitmap[i] = '0;
                page_used[i] = 0;
                home[i] = ssa_pkg::HOME_POOL;
                lists[ssa_pkg::HOME_POOL].push_back(i);
            end
            used_sum = 0;
            awaited_results = {};
            fail_count = 0;
            pending = 0;
            result_count = 0;
            ok_allocs = 0;
            ok_frees = 0;
            error_results = 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                guess = predict_outcome(req_mon.command, int'(req_mon.page_index),
                                        int'(req_mon.slot_index));
                awaited_results.push_back(guess);
                if (guess.status == ssa_pkg::ST_OK)
                begin
                    if (req_mon.command == ssa_pkg::CMD_ALLOC)
                        ok_allocs++;
                    else
                        ok_frees++;
                end
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                seen = '{rsp_mon.status, rsp_mon.granted_page, rsp_mon.granted_slot,
                         rsp_mon.used_slots_total, rsp_mon.held_pages};
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected beat %p", seen);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.status != ssa_pkg::ST_OK) error_results++;
                    if (seen.status !== want.status || seen.granted_page !== want.granted_page ||
                        seen.granted_slot !== want.granted_slot ||
                        seen.used_slots_total !== want.used_slots_total ||
                        seen.held_pages !== want.held_pages)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, seen);
                    end
                end
            end
            pending = awaited_results.size();
        end
    end
endmodule

FILE: tb/slab_slot_allocator_unit_tb.sv
module slab_slot_allocator_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [6:0]  slots_cfg;
    logic [4:0]  keep_cfg;
    logic        random_cfg;
    logic [31:0] seed_cfg;
    int          fail_count, pending, result_count, ok_results, ok_frees, error_results;
    int          send_idle, recv_idle;
    int          hold_off;
    logic        hold_start;
    logic        hold_taken;

    ssa_req_if req ();
    ssa_rsp_if rsp ();

    slab_slot_allocator_unit u_top (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    slab_slot_allocator_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n), .req_mon(req.sink), .rsp_mon(rsp.sink),
        .slots_cfg(slots_cfg), .keep_cfg(keep_cfg), .random_cfg(random_cfg),
        .seed_cfg(seed_cfg), .fail_count(fail_count), .pending(pending),
        .result_count(result_count), .ok_allocs(ok_results), .ok_frees(ok_frees),
        .error_results(error_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rsp.ready  = 1'b0;
        hold_off   = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_off   = 200;
            end
            if (hold_off > 0)
            begin
                rsp.ready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ssa_pkg::REG_SLOTS:  slots_cfg  = value[6:0];
            ssa_pkg::REG_KEEP:   keep_cfg   = value[4:0];
            ssa_pkg::REG_RANDOM: random_cfg = value[0];
            default:             seed_cfg   = value;
        endcase
    endtask

    task automatic drain();
        while (pending != 0 || req.valid) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic offer(logic cmd, logic [3:0] pg, logic [5:0] sl);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.page_index <= pg;
        req.slot_index <= sl;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic finish_offer();
        req.valid <= 1'b0;
    endtask

    task automatic free_live();
        int k;
        logic [3:0] pg;
        logic [5:0] sl;
        k = $urandom_range(15);
        pg = 4'(k);
        sl = 6'($urandom_range(slots_cfg > 64 ? 63 : (slots_cfg == 0 ? 0 : slots_cfg - 1)));
        offer(ssa_pkg::CMD_FREE, pg, sl);
    endtask

    task automatic run_phase(int n, int alloc_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < alloc_pct)
                offer(ssa_pkg::CMD_ALLOC, 4'($urandom), 6'($urandom));
            else if ($urandom_range(9) == 0)
                offer(ssa_pkg::CMD_FREE, 4'($urandom), 6'($urandom));
            else
                free_live();
        end
        finish_offer();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req.valid = 1'b0; req.command = 1'b0; req.page_index = '0; req.slot_index = '0;
        hold_start = 1'b0;
        slots_cfg = ssa_pkg::SLOTS_RESET; keep_cfg = ssa_pkg::KEEP_RESET;
        random_cfg = 1'b0; seed_cfg = '0;
        send_idle = 0; recv_idle = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drain();

        offer(ssa_pkg::CMD_FREE, 4'd0, 6'd0);
        offer(ssa_pkg::CMD_FREE, 4'd15, 6'd63);
        offer(ssa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        offer(ssa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        offer(ssa_pkg::CMD_FREE, 4'd0, 6'd1);
        offer(ssa_pkg::CMD_FREE, 4'd0, 6'd1);
        offer(ssa_pkg::CMD_FREE, 4'd0, 6'd0);
        finish_offer();
        drain();
        reg_write(ssa_pkg::REG_SLOTS, 32'd1);
        reg_write(ssa_pkg::REG_KEEP, 32'd1);
        drain();
        for (int i = 0; i < 18; i++) offer(ssa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        offer(ssa_pkg::CMD_FREE, 4'd3, 6'd5);
        offer(ssa_pkg::CMD_FREE, 4'd3, 6'd0);
        offer(ssa_pkg::CMD_FREE, 4'd4, 6'd0);
        offer(ssa_pkg::CMD_FREE, 4'd5, 6'd0);
        finish_offer();
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 3)
                0: begin send_idle = 34; recv_idle = 68; end
                1: begin send_idle = 68; recv_idle = 34; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            reg_write(ssa_pkg::REG_SLOTS, ph == 1 ? 32'd0 : ph == 2 ? 32'd127 :
                                          ph == 4 ? 32'd64 : 32'($urandom_range(2, 12)));
            reg_write(ssa_pkg::REG_KEEP,
                      ph == 3 ? 32'd0 : ph == 5 ? 32'd31 : 32'($urandom_range(1, 16)));
            reg_write(ssa_pkg::REG_RANDOM, 32'(ph % 2));
            reg_write(ssa_pkg::REG_SEED, ph == 7 ? 32'hFFFF_FFFF : $urandom);
            drain();
            if (ph == 2) hold_start = 1'b1;
            run_phase(150, ph == 6 ? 85 : 55);
            drain();
            reg_write(ssa_pkg::REG_SLOTS, 32'd3);
            drain();
            run_phase(10, 30);
            drain();
        end

        $display("checked %0d beats: %0d allocs and %0d frees granted, %0d rejected",
                 result_count, ok_results, ok_frees, error_results);
        $display("slot counts from 1 to 64 and beyond, keep limits 0 to 31, both search modes");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
